### design/pssf_pkg.sv
// shared constants and types for the polygon scanline span finder
// no dependencies
package pssf_pkg;

    localparam int MaxVertices = 64;
    localparam int AddrW       = $clog2(MaxVertices);
    localparam int CountW      = $clog2(MaxVertices + 1);

    localparam logic signed [15:0] BoxMinReset = 16'sd10000;
    localparam logic signed [15:0] BoxMaxReset = -16'sd10000;
    localparam logic [12:0] WidthReset  = 13'd640;
    localparam logic [12:0] HeightReset = 13'd480;

    localparam logic CfgWidth  = 1'b0;
    localparam logic CfgHeight = 1'b1;

    localparam logic OpVertex = 1'b0;
    localparam logic OpQuery  = 1'b1;

    // divider request and response
    typedef struct packed {
        logic        go;
        logic [31:0] dividend;
        logic [16:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

### design/pssf_divider.sv
// restoring radix-2 divider, one quotient bit per cycle
// depends on pssf_pkg
module pssf_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  pssf_pkg::div_req_t req,
    output pssf_pkg::div_rsp_t rsp
);
    import pssf_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [17:0] rem_reg, rem_next;
    logic [16:0] dvs_reg, dvs_next;
    logic        done_reg, done_next;
    logic [17:0] trial;

    // load on a request, else one shift-subtract step while busy
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        trial     = {rem_reg[16:0], quo_reg[31]};
        if (req.go)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            quo_next  = req.dividend;
            rem_next  = 18'd0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

### design/polygon_scanline_span_finder_core.sv
// top level: vertex store, bounding box, query sequencer with a divider
// depends on pssf_pkg and pssf_divider
//
// A vertex request is taken without raising busy. A query request walks the
// stored edges one at a time: S_RD_A and S_RD_B read the two vertices, S_EDGE
// tests the edge, and a sloped edge crossing the row then waits on the
// 32-step divider (S_DIV) before multiply (S_MUL) and accumulate (S_ACC).
// Busy stays high through S_FIN and the result follows on the next cycle. A
// row outside the clamped box, or an empty store, ends the query at S_RD_A.
// Each query yields one result with done high for one cycle, and the
// receiver cannot stall it.
module polygon_scanline_span_finder_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic               new_polygon,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    output logic               done,
    output logic [14:0]        span_start,
    output logic signed [15:0] span_end,
    output logic               span_valid,
    output logic               overflowed,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [12:0]        cfg_data
);
    import pssf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD_A  = 3'd1;
    localparam logic [2:0] S_RD_B  = 3'd2;
    localparam logic [2:0] S_EDGE  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_ACC   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [15:0] mem_x [MaxVertices];
    logic [15:0] mem_y [MaxVertices];

    logic [2:0]  state_reg, state_next;
    logic [CountW-1:0] count_reg;
    logic signed [15:0] bminx_reg, bminy_reg, bmaxx_reg, bmaxy_reg;
    logic        drop_reg;
    logic [12:0] fw_reg, fh_reg;
    logic signed [15:0] qy_reg;
    logic [AddrW-1:0] idx_reg;
    logic [AddrW-1:0] rd_addr;
    logic signed [15:0] rdx_reg, rdy_reg;
    logic signed [15:0] ax_reg, ay_reg;
    logic signed [17:0] st_reg, en_reg;
    logic signed [16:0] tx, ty, bx, by;
    logic signed [16:0] run_reg, tx_reg;
    logic signed [50:0] prod_reg;
    logic        done_reg, val_reg;
    logic [14:0] ss_reg;
    logic signed [15:0] se_reg;
    logic        last_edge;
    logic signed [15:0] lo, hi;
    logic signed [17:0] cs, ce;
    logic        inrow;
    div_req_t    dreq;
    div_rsp_t    drsp;

    pssf_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign last_edge = ({1'b0, idx_reg} + 1'b1) == count_reg;

    // store read address: the next vertex around the loop in S_RD_A, else the current one
    always_comb
    begin
        if (state_reg == S_RD_A)
            rd_addr = last_edge ? '0 : idx_reg + 1'b1;
        else
            rd_addr = idx_reg;
    end

    // vertex store
    always_ff @(posedge clk)
    begin
        if (start && !busy && op == OpVertex
            && (new_polygon || count_reg < CountW'(MaxVertices)))
        begin
            mem_x[new_polygon ? '0 : count_reg[AddrW-1:0]] <= coord_x;
            mem_y[new_polygon ? '0 : count_reg[AddrW-1:0]] <= coord_y;
        end
        rdx_reg <= mem_x[rd_addr];
        rdy_reg <= mem_y[rd_addr];
    end

    // edge endpoints ordered top to bottom
    always_comb
    begin
        if (rdy_reg < ay_reg)
        begin
            tx = 17'(rdx_reg); ty = 17'(rdy_reg);
            bx = 17'(ax_reg);  by = 17'(ay_reg);
        end
        else
        begin
            tx = 17'(ax_reg);  ty = 17'(ay_reg);
            bx = 17'(rdx_reg); by = 17'(rdy_reg);
        end
    end

    // divider request on a sloped edge crossing the row
    always_comb
    begin
        dreq.go       = 1'b0;
        dreq.dividend = {16'(17'(qy_reg) - ty), 16'd0};
        dreq.divisor  = 17'(by - ty);
        if (state_reg == S_EDGE && ty <= 17'(qy_reg) && by >= 17'(qy_reg)
            && by != ty)
            dreq.go = 1'b1;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start && op == OpQuery) state_next = S_RD_A;
            S_RD_A:
                if (count_reg == '0 || !inrow)
                    state_next = S_FIN;
                else
                    state_next = S_RD_B;
            S_RD_B: state_next = S_EDGE;
            S_EDGE:
                if (ty > 17'(qy_reg) || by < 17'(qy_reg) || by == ty)
                    state_next = last_edge ? S_FIN : S_RD_A;
                else
                    state_next = S_DIV;
            S_DIV:
                if (drsp.done) state_next = S_MUL;
            S_MUL: state_next = S_ACC;
            S_ACC: state_next = last_edge ? S_FIN : S_RD_A;
            S_FIN: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // clamped row range and span
    always_comb
    begin
        lo = (bminy_reg < 0) ? 16'sd0 : bminy_reg;
        hi = (17'(bmaxy_reg) >= $signed({4'd0, fh_reg}))
             ? 16'($signed({4'd0, fh_reg}) - 17'sd1) : bmaxy_reg;
        inrow = (qy_reg >= lo) && (qy_reg <= hi);
        ce = (en_reg > 18'($signed({4'd0, fw_reg}) - 17'sd1))
             ? 18'($signed({4'd0, fw_reg}) - 17'sd1) : en_reg;
        cs = (st_reg < 0) ? 18'sd0 : st_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            bminx_reg <= BoxMinReset; bminy_reg <= BoxMinReset;
            bmaxx_reg <= BoxMaxReset; bmaxy_reg <= BoxMaxReset;
            drop_reg  <= 1'b0;
            fw_reg    <= WidthReset;
            fh_reg    <= HeightReset;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FIN);
            if (cfg_valid)
            begin
                if (cfg_index == CfgWidth) fw_reg <= cfg_data;
                else                       fh_reg <= cfg_data;
            end
            if (start && !busy && op == OpVertex)
            begin
                if (new_polygon)
                begin
                    count_reg <= CountW'(1);
                    drop_reg  <= 1'b0;
                    bminx_reg <= (coord_x < BoxMinReset) ? coord_x : BoxMinReset;
                    bminy_reg <= (coord_y < BoxMinReset) ? coord_y : BoxMinReset;
                    bmaxx_reg <= (coord_x > BoxMaxReset) ? coord_x : BoxMaxReset;
                    bmaxy_reg <= (coord_y > BoxMaxReset) ? coord_y : BoxMaxReset;
                end
                else if (count_reg >= CountW'(MaxVertices))
                    drop_reg <= 1'b1;
                else
                begin
                    count_reg <= count_reg + 1'b1;
                    if (coord_x < bminx_reg) bminx_reg <= coord_x;
                    if (coord_y < bminy_reg) bminy_reg <= coord_y;
                    if (coord_x > bmaxx_reg) bmaxx_reg <= coord_x;
                    if (coord_y > bmaxy_reg) bmaxy_reg <= coord_y;
                end
            end
        end
    end

    // query datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                qy_reg  <= coord_y;
                idx_reg <= '0;
                st_reg  <= 18'(bmaxx_reg);
                en_reg  <= 18'(bminx_reg);
            end
            S_RD_B:
            begin
                ax_reg <= rdx_reg;
                ay_reg <= rdy_reg;
            end
            S_RD_A:
            begin
                ax_reg <= rdx_reg;
                ay_reg <= rdy_reg;
            end
            S_EDGE:
            begin
                run_reg <= bx - tx;
                tx_reg  <= tx;
                if (ty <= 17'(qy_reg) && by >= 17'(qy_reg) && by == ty)
                begin
                    if (st_reg > 18'((tx < bx) ? tx : bx))
                        st_reg <= 18'((tx < bx) ? tx : bx);
                    if (en_reg < 18'((tx < bx) ? bx : tx))
                        en_reg <= 18'((tx < bx) ? bx : tx);
                end
                if (state_next != S_DIV && !last_edge) idx_reg <= idx_reg + 1'b1;
            end
            S_DIV: ;
            S_MUL:
                prod_reg <= $signed({1'b0, drsp.quotient[16:0]}) * run_reg
                            + 51'sd32768;
            S_ACC:
            begin
                if (18'(prod_reg >>> 16) + 18'(tx_reg) < st_reg)
                    st_reg <= 18'(prod_reg >>> 16) + 18'(tx_reg);
                if (18'(prod_reg >>> 16) + 18'(tx_reg) > en_reg)
                    en_reg <= 18'(prod_reg >>> 16) + 18'(tx_reg);
                if (!last_edge) idx_reg <= idx_reg + 1'b1;
            end
            S_FIN:
            begin
                val_reg <= inrow && count_reg != '0 && cs <= ce;
                ss_reg  <= (inrow && cs <= ce) ? cs[14:0] : 15'd0;
                se_reg  <= (inrow && cs <= ce) ? ce[15:0] : 16'sd0;
            end
            default: ;
        endcase
    end

    assign done       = done_reg;
    assign span_start = ss_reg;
    assign span_end   = se_reg;
    assign span_valid = val_reg;
    assign overflowed = drop_reg;
endmodule

### design/pssf_checker.sv
// port-level checks for the span finder core
// depends on polygon_scanline_span_finder_core
module pssf_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic op,
    input logic done,
    input logic span_valid,
    input logic [14:0] span_start,
    input logic signed [15:0] span_end
);
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op |=> busy) else $error("query not taken");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !span_valid |-> span_start == 0 && span_end == 0)
        else $error("invalid span not zero");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
endmodule

bind polygon_scanline_span_finder_core pssf_checker u_chk (.*);
